// File: rtl/sst_pkg.sv
// ----------------------------------------------------------------------------
// sst_pkg
// shared types and constants for the sorted set table
// ----------------------------------------------------------------------------
package sst_pkg;

  localparam int CAPACITY  = 256;
  localparam int KEY_WIDTH = 32;
  localparam int IDX_W     = $clog2(CAPACITY);
  localparam int CNT_W     = $clog2(CAPACITY + 1);
  localparam int POS_W     = 8;
  localparam int COUNT_W   = 9;

  // operation codes
  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_DELETE = 2'd1;
  localparam logic [1:0] MODE_LOOKUP = 2'd2;

  typedef logic signed [KEY_WIDTH-1:0] key_t;

  typedef struct packed {
    logic [1:0] mode;
    key_t       key;
  } req_t;

  typedef struct packed {
    logic               success;
    logic               full_res;
    logic [POS_W-1:0]   position;
    logic [COUNT_W-1:0] count;
  } res_t;

  // per-cycle commands broadcast to every cell
  typedef struct packed {
    logic cmp_en;
    logic ins_en;
    logic del_en;
  } cell_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_APPLY
  } state_t;

endpackage

// File: rtl/sst_cell.sv
// ----------------------------------------------------------------------------
// sst_cell
// one slot of the sorted chain: holds a key, compares it and shifts
// ----------------------------------------------------------------------------
module sst_cell import sst_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  cell_ctl_t ctl,
  input  key_t      req_key,
  input  key_t      prev_key,
  input  logic      prev_occ,
  input  logic      prev_lt,
  input  key_t      next_key,
  input  logic      next_occ,
  output key_t      key,
  output logic      occ,
  output logic      lt,
  output logic      eq,
  output logic      first
);

  // first slot whose key is not below the request
  assign first = !lt && prev_lt;

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= 1'b0;
      lt  <= 1'b0;
      eq  <= 1'b0;
    end else begin
      if (ctl.cmp_en) begin
        lt <= occ && (key < req_key);
        eq <= occ && (key == req_key);
      end
      if (ctl.ins_en && !lt) begin
        occ <= first ? 1'b1 : prev_occ;
      end else if (ctl.del_en && !lt) begin
        occ <= next_occ;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ins_en && !lt) begin
      key <= first ? req_key : prev_key;
    end else if (ctl.del_en && !lt) begin
      key <= next_key;
    end
  end

endmodule

// File: rtl/sorted_set_table_core.sv
// ----------------------------------------------------------------------------
// sorted_set_table_core
// ordered set of distinct signed keys kept in a chain of compare/shift cells
// ----------------------------------------------------------------------------
// usage
//   request channel req_valid/req_ready/req carries mode and key; mode is
//   insert, delete or lookup, any other code leaves the set alone
//   result channel res_valid/res_ready/res returns exactly one transaction
//   per request: success, full flag, sorted position and key count after the
//   operation; once a request is taken, all cells compare against the key
//   in the compare state, then the apply state decodes the position, shifts
//   the chain and loads the result register
//   requests go through one at a time: the block takes a new request only
//   as the compare then shift pass through the cell chain ends
//   the result sits in an output register, so a request is taken while the
//   previous result waits; a stalled receiver holds the block in its shift
//   step until the result register frees up
//   reset empties the set at once (cell occupancy flags clear), no sweep
// ----------------------------------------------------------------------------
module sorted_set_table_core import sst_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic res_valid,
  input  logic res_ready,
  output res_t res
);

  state_t state, state_next;
  req_t   req_q;
  logic [CNT_W-1:0] count, count_next;
  res_t   res_next;
  logic   res_load;

  cell_ctl_t ctl;

  key_t                cell_key [CAPACITY];
  logic [CAPACITY-1:0] cell_occ;
  logic [CAPACITY-1:0] cell_lt;
  logic [CAPACITY-1:0] cell_eq;
  logic [CAPACITY-1:0] cell_first;

  logic             found;
  logic             is_full;
  logic             out_free;
  logic [IDX_W-1:0] pos;
  logic             ins_ok;
  logic             del_ok;

  // index of the single set bit, zero when none
  function automatic logic [IDX_W-1:0] encode(input logic [CAPACITY-1:0] v);
    logic [IDX_W-1:0] r;
    r = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (v[i]) begin
        r = r | IDX_W'(i);
      end
    end
    return r;
  endfunction

  // the cell chain; cell 0 sees a below-key neighbor so it can be first
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    key_t p_key, n_key;
    logic p_occ, p_lt, n_occ;

    if (i == 0) begin : g_head
      assign p_key = '0;
      assign p_occ = 1'b0;
      assign p_lt  = 1'b1;
    end else begin : g_body
      assign p_key = cell_key[i-1];
      assign p_occ = cell_occ[i-1];
      assign p_lt  = cell_lt[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign n_key = '0;
      assign n_occ = 1'b0;
    end else begin : g_inner
      assign n_key = cell_key[i+1];
      assign n_occ = cell_occ[i+1];
    end

    sst_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctl      (ctl),
      .req_key  (req_q.key),
      .prev_key (p_key),
      .prev_occ (p_occ),
      .prev_lt  (p_lt),
      .next_key (n_key),
      .next_occ (n_occ),
      .key      (cell_key[i]),
      .occ      (cell_occ[i]),
      .lt       (cell_lt[i]),
      .eq       (cell_eq[i]),
      .first    (cell_first[i])
    );
  end

  // compare flags are registered in the cells, decode them here
  assign found    = |cell_eq;
  assign pos      = found ? encode(cell_eq) : encode(cell_first);
  assign is_full  = (count == CNT_W'(CAPACITY));
  assign out_free = !res_valid || res_ready;

  always_comb begin
    state_next = state;
    count_next = count;
    req_ready  = 1'b0;
    res_load   = 1'b0;
    ins_ok     = 1'b0;
    del_ok     = 1'b0;
    ctl        = '0;
    res_next   = '0;

    unique case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          state_next = ST_CMP;
        end
      end
      ST_CMP: begin
        ctl.cmp_en = 1'b1;
        state_next = ST_APPLY;
      end
      ST_APPLY: begin
        if (out_free) begin
          res_load  = 1'b1;
          req_ready = 1'b1;
          ins_ok    = (req_q.mode == MODE_INSERT) && !found && !is_full;
          del_ok    = (req_q.mode == MODE_DELETE) && found;
          ctl.ins_en = ins_ok;
          ctl.del_en = del_ok;
          if (ins_ok) begin
            count_next = count + 1'b1;
          end else if (del_ok) begin
            count_next = count - 1'b1;
          end
          res_next.success  = ins_ok || del_ok ||
                              ((req_q.mode == MODE_LOOKUP) && found);
          res_next.full_res = (req_q.mode == MODE_INSERT) && !found && is_full;
          // duplicate insert still reports where the key sits
          if (ins_ok || (found && (req_q.mode == MODE_INSERT ||
                                   req_q.mode == MODE_DELETE ||
                                   req_q.mode == MODE_LOOKUP))) begin
            res_next.position = POS_W'(pos);
          end
          res_next.count = COUNT_W'(count_next);
          state_next = req_valid ? ST_CMP : ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      req_q <= req;
    end
    if (res_load) begin
      res <= res_next;
    end
  end

endmodule

// File: dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for sorted_set_table_core
// ----------------------------------------------------------------------------
// a short directed run covers the empty set, the extreme keys, duplicates,
// misses and the unused operation code; random traffic then fills the set
// to capacity, churns it while full and drains it again, with random stalls
// on both handshakes in its first two thirds; every result transaction is
// checked against a sorted-queue predictor kept in the scoreboard class
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sst_pkg::*;

  localparam time CLK_PERIOD   = 10ns;
  localparam int  RANDOM_ITEMS = 1080;
  localparam int  CHURN_ITEMS  = 60;
  localparam int  MIXED_ITEMS  = 150;

  // the one code the block must leave alone
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  localparam key_t KEY_MIN = {1'b1, {(KEY_WIDTH-1){1'b0}}};
  localparam key_t KEY_MAX = {1'b0, {(KEY_WIDTH-1){1'b1}}};

  // random traffic moves through these stages so the set really fills up
  typedef enum {PH_GROW, PH_CHURN, PH_SHRINK, PH_MIXED} phase_e;

  // --------------------------------------------------------------------------
  // scoreboard: mirrors the set as an ascending queue of keys and keeps the
  // results still owed by the block, oldest first
  // --------------------------------------------------------------------------
  class set_ledger;
    key_t keys[$];
    res_t owed[$];
    int   errors;
    int   checked;
    int   n_req, n_ins, n_del, n_look, n_unused;
    int   n_full, n_dup, peak;

    task report(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      errors++;
    endtask

    // note one accepted request transaction and queue its expected result
    function void note_request(req_t r);
      res_t        exp;
      int unsigned at;
      bit          hit;
      exp = '0;
      at  = 0;
      // first slot whose key is not below the request key (signed order)
      while (at < keys.size() && keys[at] < r.key) at++;
      hit = (at < keys.size()) && (keys[at] == r.key);
      n_req++;
      case (r.mode)
        MODE_INSERT: begin
          n_ins++;
          if (hit) begin
            // duplicate: refused, reports where the key already sits
            exp.position = at[POS_W-1:0];
            n_dup++;
          end else if (keys.size() >= CAPACITY) begin
            exp.full_res = 1'b1;
            n_full++;
          end else begin
            keys.insert(at, r.key);
            exp.success  = 1'b1;
            exp.position = at[POS_W-1:0];
          end
        end
        MODE_DELETE: begin
          n_del++;
          if (hit) begin
            keys.delete(at);
            exp.success  = 1'b1;
            exp.position = at[POS_W-1:0];
          end
        end
        MODE_LOOKUP: begin
          n_look++;
          if (hit) begin
            exp.success  = 1'b1;
            exp.position = at[POS_W-1:0];
          end
        end
        default: n_unused++;
      endcase
      exp.count = COUNT_W'(keys.size());
      if (keys.size() > peak) peak = keys.size();
      owed.push_back(exp);
    endfunction

    // compare one accepted result transaction with the oldest expectation
    task check_result(res_t got);
      res_t exp;
      if (owed.size() == 0) begin
        report($sformatf("result with nothing expected: %p", got));
        return;
      end
      exp = owed.pop_front();
      checked++;
      if (got.success !== exp.success)
        report($sformatf("result %0d success %b, expected %b", checked, got.success,
                         exp.success));
      if (got.full_res !== exp.full_res)
        report($sformatf("result %0d full_res %b, expected %b", checked, got.full_res,
                         exp.full_res));
      if (got.position !== exp.position)
        report($sformatf("result %0d position %0d, expected %0d", checked, got.position,
                         exp.position));
      if (got.count !== exp.count)
        report($sformatf("result %0d count %0d, expected %0d", checked, got.count,
                         exp.count));
    endtask
  endclass

  // --------------------------------------------------------------------------
  // clock, dut and shared state
  // --------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst;
  logic req_valid;
  logic req_ready;
  req_t req;
  logic res_valid;
  logic res_ready;
  res_t res;

  set_ledger ledger;

  // stall percentages, changed after the first and second thirds of the random run
  int send_idle_pct = 9;
  int recv_idle_pct = 67;

  always #(CLK_PERIOD / 2) clk = ~clk;

  sorted_set_table_core dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // --------------------------------------------------------------------------
  // request driver
  // --------------------------------------------------------------------------
  // drives one request transaction and holds it until accepted; valid stays
  // high into the next call unless an idle gap is chosen, so valid is never
  // dropped and raised in the same step
  task automatic push_request(input logic [1:0] op, input key_t key);
    req_t item;
    item.mode = op;
    item.key  = key;
    req       <= item;
    req_valid <= 1'b1;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    ledger.note_request(item);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  // operation mix per stage; whatever is left over goes to the unused code
  function automatic logic [1:0] pick_mode(phase_e ph);
    int r;
    int w_ins, w_del, w_look;
    r = $urandom_range(0, 99);
    case (ph)
      PH_GROW:   begin w_ins = 88; w_del = 4;  w_look = 6;  end
      PH_CHURN:  begin w_ins = 45; w_del = 25; w_look = 25; end
      PH_SHRINK: begin w_ins = 8;  w_del = 80; w_look = 10; end
      default:   begin w_ins = 35; w_del = 30; w_look = 30; end
    endcase
    if (r < w_ins) return MODE_INSERT;
    if (r < w_ins + w_del) return MODE_DELETE;
    if (r < w_ins + w_del + w_look) return MODE_LOOKUP;
    return MODE_UNUSED;
  endfunction

  // keys: mostly held keys for deletes and lookups, mostly fresh for inserts;
  // neighbors of held keys give near misses, extremes stress the signed order
  function automatic key_t pick_key(bit fresh_bias);
    int   r;
    key_t held;
    r = $urandom_range(0, 99);
    if (ledger.keys.size() != 0)
      held = ledger.keys[$urandom_range(0, ledger.keys.size() - 1)];
    else
      held = key_t'($urandom);
    if (fresh_bias) begin
      if (r < 20) return held;
      if (r < 30) return ($urandom_range(0, 1) != 0) ? held + 1 : held - 1;
    end else begin
      if (r < 55) return held;
      if (r < 70) return ($urandom_range(0, 1) != 0) ? held + 1 : held - 1;
    end
    if (r < 80) begin
      case ($urandom_range(0, 3))
        0:       return KEY_MIN;
        1:       return KEY_MAX;
        2:       return '0;
        default: return '1;
      endcase
    end
    return key_t'($urandom);
  endfunction

  // --------------------------------------------------------------------------
  // result receiver: random back-pressure, checks every accepted transaction
  // --------------------------------------------------------------------------
  initial begin
    res_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && res_valid && res_ready)
        ledger.check_result(res);
      res_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    phase_e     phase;
    int         stint;
    logic [1:0] op;
    key_t       key;

    ledger    = new();
    rst       <= 1'b1;
    req_valid <= 1'b0;
    req       <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty set first, then extremes, duplicates and misses
    push_request(MODE_LOOKUP, '0);           // lookup on empty set
    push_request(MODE_DELETE, key_t'(5));    // delete on empty set
    push_request(MODE_UNUSED, '1);           // unused code, nothing changes
    push_request(MODE_INSERT, '0);
    push_request(MODE_INSERT, KEY_MIN);      // goes in front
    push_request(MODE_INSERT, KEY_MAX);      // goes at the end
    push_request(MODE_INSERT, '1);           // -1 lands between min and zero
    push_request(MODE_INSERT, key_t'(1));
    push_request(MODE_INSERT, '0);           // duplicate insert
    push_request(MODE_LOOKUP, KEY_MIN);
    push_request(MODE_LOOKUP, KEY_MAX);
    push_request(MODE_LOOKUP, key_t'(2));    // lookup miss
    push_request(MODE_UNUSED, KEY_MAX);
    push_request(MODE_DELETE, '0);           // delete from the middle
    push_request(MODE_DELETE, '0);           // delete miss
    push_request(MODE_DELETE, KEY_MAX);      // delete the last key
    push_request(MODE_DELETE, KEY_MIN);      // delete the first key
    push_request(MODE_INSERT, key_t'(32'h5555_5555));
    push_request(MODE_INSERT, key_t'(32'hAAAA_AAAA));
    push_request(MODE_LOOKUP, key_t'(32'hAAAA_AAAA));
    push_request(MODE_LOOKUP, key_t'(32'h5555_5555));

    // random: fill to capacity, churn while full, drain, mix, and again
    phase = PH_GROW;
    stint = 0;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS / 3) begin
        send_idle_pct = 67;
        recv_idle_pct = 9;
      end
      if (i == 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (phase)
        PH_GROW: begin
          if (ledger.keys.size() == CAPACITY) begin
            phase = PH_CHURN;
            stint = CHURN_ITEMS;
          end
        end
        PH_CHURN: begin
          stint--;
          if (stint == 0) phase = PH_SHRINK;
        end
        PH_SHRINK: begin
          if (ledger.keys.size() <= 8) begin
            phase = PH_MIXED;
            stint = MIXED_ITEMS;
          end
        end
        default: begin
          stint--;
          if (stint == 0) phase = PH_GROW;
        end
      endcase
      op  = pick_mode(phase);
      key = pick_key(op == MODE_INSERT);
      push_request(op, key);
    end
    req_valid <= 1'b0;

    // drain: every request gets one result, then a short quiet tail
    while (ledger.owed.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("covered %0d requests: %0d inserts, %0d deletes, %0d lookups, %0d unused code",
             ledger.n_req, ledger.n_ins, ledger.n_del, ledger.n_look, ledger.n_unused);
    $display("peak occupancy %0d of %0d, %0d full refusals, %0d duplicate inserts, %0d errors",
             ledger.peak, CAPACITY, ledger.n_full, ledger.n_dup, ledger.errors);
    if (ledger.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // watchdog
  // --------------------------------------------------------------------------
  initial begin
    #5ms;
    $display("timeout: results still outstanding");
    $display("Regression FAIL");
    $finish;
  end

endmodule
